/* rtl/midi_byte_stream_parser_core_defines.svh */
// ----------------------------------------------------------------------------
// MIDI parser assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_BYTE_STREAM_PARSER_CORE_DEFINES_SVH
`define MIDI_BYTE_STREAM_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define MBSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mbsp_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI parser package
// Result kinds, status codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package mbsp_pkg;

    typedef enum logic [2:0] {
        KIND_CHANNEL    = 3'd0,
        KIND_REALTIME   = 3'd1,
        KIND_SYSEX_END  = 3'd2,
        KIND_SYSCOMMON  = 3'd3,
        KIND_SYSEX_DATA = 3'd4,
        KIND_STRAY      = 3'd5
    } kind_t;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [7:0] NO_STATUS   = 8'h00;

    localparam logic [3:0] OP_NOTE_OFF = 4'h8;
    localparam logic [3:0] OP_NOTE_ON  = 4'h9;
    localparam logic [3:0] OP_PROGRAM  = 4'hC;
    localparam logic [3:0] OP_PRESSURE = 4'hD;
    localparam logic [3:0] OP_SYSTEM   = 4'hF;

    localparam logic [6:0] NOTE_OFF_VELOCITY = 7'h40;

    typedef struct packed {
        logic [1:0] data_count;
        logic [6:0] data_b;
        logic [6:0] data_a;
        logic       all_channels;
        logic [3:0] channel;
        logic [7:0] opcode;
        kind_t      kind;
    } result_t;

    function automatic logic is_realtime(input logic [7:0] b);
        return (b == 8'hF8) || (b == 8'hFA) || (b == 8'hFB) ||
               (b == 8'hFC) || (b == 8'hFE) || (b == 8'hFF);
    endfunction

endpackage

`default_nettype wire

/* rtl/midi_byte_stream_parser_core.sv */
// ----------------------------------------------------------------------------
// MIDI byte stream parser core
// A byte is registered in the input stage, then its result in the result stage on m_axis.
// Throughput: one byte per cycle while m_axis is not stalled; the decode between
// input and result registers updates running status in the same cycle.
// Reset (aresetn low, synchronous): both stages empty, no running status.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_byte_stream_parser_core_defines.svh"

module midi_byte_stream_parser_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] opcode, [11:8] channel,
                                             // [18:12] data_a, [25:19] data_b,
                                             // [27:26] data_count, [31:28] zero
    output logic [3:0]       m_axis_tuser    // [2:0] kind, [3] all_channels
);

    // input stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // parser state
    logic [7:0]  status_reg, status_next;
    logic        seen_reg, seen_next;
    logic [6:0]  first_reg, first_next;

    // result stage
    logic                 out_valid_reg;
    mbsp_pkg::result_t    out_res_reg;
    mbsp_pkg::result_t    res;
    logic                 has_res;
    logic                 advance;

    always_comb begin
        logic [7:0] b;
        logic [3:0] op;
        logic [3:0] ch;
        logic       one_byte;
        b        = in_byte_reg;
        op       = status_reg[7:4];
        ch       = status_reg[3:0];
        one_byte = (op == mbsp_pkg::OP_PROGRAM) || (op == mbsp_pkg::OP_PRESSURE);

        status_next      = status_reg;
        seen_next        = seen_reg;
        first_next       = first_reg;
        has_res          = 1'b0;
        res.kind         = mbsp_pkg::KIND_STRAY;
        res.opcode       = 8'h00;
        res.channel      = 4'h0;
        res.all_channels = 1'b1;
        res.data_a       = 7'h00;
        res.data_b       = 7'h00;
        res.data_count   = 2'd0;

        if (b[7]) begin
            if (b[7:4] != mbsp_pkg::OP_SYSTEM || b == mbsp_pkg::SYSEX_START) begin
                status_next = b;
                seen_next   = 1'b0;
            end else if (b == mbsp_pkg::SYSEX_END) begin
                status_next = mbsp_pkg::NO_STATUS;
                seen_next   = 1'b0;
                has_res     = 1'b1;
                res.kind    = mbsp_pkg::KIND_SYSEX_END;
                res.opcode  = b;
            end else if (mbsp_pkg::is_realtime(b)) begin
                has_res     = 1'b1;
                res.kind    = mbsp_pkg::KIND_REALTIME;
                res.opcode  = b;
            end else begin
                status_next = mbsp_pkg::NO_STATUS;
                seen_next   = 1'b0;
                has_res     = 1'b1;
                res.kind    = mbsp_pkg::KIND_SYSCOMMON;
                res.opcode  = b;
            end
        end else if (status_reg == mbsp_pkg::SYSEX_START) begin
            has_res        = 1'b1;
            res.kind       = mbsp_pkg::KIND_SYSEX_DATA;
            res.opcode     = mbsp_pkg::SYSEX_START;
            res.data_a     = b[6:0];
            res.data_count = 2'd1;
        end else if (!status_reg[7] || op == mbsp_pkg::OP_SYSTEM) begin
            has_res        = 1'b1;
            res.kind       = mbsp_pkg::KIND_STRAY;
            res.data_a     = b[6:0];
            res.data_count = 2'd1;
        end else if (one_byte) begin
            seen_next        = 1'b0;
            has_res          = 1'b1;
            res.kind         = mbsp_pkg::KIND_CHANNEL;
            res.opcode       = {op, 4'h0};
            res.channel      = ch;
            res.all_channels = 1'b0;
            res.data_a       = b[6:0];
            res.data_count   = 2'd1;
        end else if (!seen_reg) begin
            seen_next  = 1'b1;
            first_next = b[6:0];
        end else begin
            seen_next        = 1'b0;
            has_res          = 1'b1;
            res.kind         = mbsp_pkg::KIND_CHANNEL;
            res.channel      = ch;
            res.all_channels = 1'b0;
            res.data_a       = first_reg;
            res.data_count   = 2'd2;
            // note-on at zero velocity is a note-off
            if (op == mbsp_pkg::OP_NOTE_ON && b[6:0] == 7'h00) begin
                res.opcode = {mbsp_pkg::OP_NOTE_OFF, 4'h0};
                res.data_b = mbsp_pkg::NOTE_OFF_VELOCITY;
            end else begin
                res.opcode = {op, 4'h0};
                res.data_b = b[6:0];
            end
        end
    end

    // an item with no result never waits on the output side
    assign advance       = in_valid_reg && (!has_res || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= mbsp_pkg::NO_STATUS;
            seen_reg      <= 1'b0;
            first_reg     <= 7'h00;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                status_reg <= status_next;
                seen_reg   <= seen_next;
                first_reg  <= first_next;
            end
            if (advance && has_res) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && has_res) begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'h0, out_res_reg.data_count, out_res_reg.data_b,
                            out_res_reg.data_a, out_res_reg.channel, out_res_reg.opcode};
    assign m_axis_tuser  = {out_res_reg.all_channels, out_res_reg.kind};

    `MBSP_ASSERT_NOW(a_chan_fields,
        out_valid_reg && out_res_reg.kind == mbsp_pkg::KIND_CHANNEL,
        !out_res_reg.all_channels && out_res_reg.data_count != 2'd0,
        "channel message with bad flags")
    `MBSP_ASSERT_NOW(a_seen_two_byte,
        seen_reg,
        status_reg[7] && status_reg[7:4] != mbsp_pkg::OP_SYSTEM &&
        status_reg[7:4] != mbsp_pkg::OP_PROGRAM && status_reg[7:4] != mbsp_pkg::OP_PRESSURE,
        "held data byte without two-byte status")
    `MBSP_ASSERT_NEXT(a_sysex_end_clears,
        advance && in_byte_reg == mbsp_pkg::SYSEX_END,
        status_reg == mbsp_pkg::NO_STATUS && !seen_reg,
        "end of exclusive left status")

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// MIDI byte stream parser testbench
// Drives MIDI bytes into the parser and checks every result item against a
// running-status decoder kept here. A short directed opening covers field
// extremes, every opcode class and the corner cases. Three random phases
// follow, with sender and receiver gaps that change from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 250;

    // channel opcodes the package leaves unnamed
    localparam logic [3:0] OP_POLY_PRESSURE = 4'hA;
    localparam logic [3:0] OP_CONTROL       = 4'hB;
    localparam logic [3:0] OP_PITCH_BEND    = 4'hE;

    // system common, undefined system and realtime bytes
    localparam logic [7:0] MTC_QUARTER   = 8'hF1;
    localparam logic [7:0] SONG_POSITION = 8'hF2;
    localparam logic [7:0] SONG_SELECT   = 8'hF3;
    localparam logic [7:0] SYS_UNDEF_F4  = 8'hF4;
    localparam logic [7:0] SYS_UNDEF_F5  = 8'hF5;
    localparam logic [7:0] TUNE_REQUEST  = 8'hF6;
    localparam logic [7:0] TIMING_CLOCK  = 8'hF8;
    localparam logic [7:0] SYS_UNDEF_F9  = 8'hF9;
    localparam logic [7:0] RT_START      = 8'hFA;
    localparam logic [7:0] RT_CONTINUE   = 8'hFB;
    localparam logic [7:0] RT_STOP       = 8'hFC;
    localparam logic [7:0] SYS_UNDEF_FD  = 8'hFD;
    localparam logic [7:0] ACTIVE_SENSE  = 8'hFE;
    localparam logic [7:0] SYSTEM_RESET  = 8'hFF;

    class midi_event_checker;
        logic [7:0]          running_status;
        bit                  have_first;
        logic [6:0]          first_data;
        mbsp_pkg::result_t   awaited[$];
        int                  errors;

        function new();
            running_status = mbsp_pkg::NO_STATUS;
            have_first     = 1'b0;
            first_data     = '0;
            errors         = 0;
        endfunction

        function bit is_rt_byte(logic [7:0] b);
            return b == TIMING_CLOCK || b == RT_START || b == RT_CONTINUE ||
                   b == RT_STOP || b == ACTIVE_SENSE || b == SYSTEM_RESET;
        endfunction

        // decode one accepted byte; queue the event it completes, if any
        function void note_byte(logic [7:0] b);
            mbsp_pkg::result_t r;
            logic [3:0]        op;
            logic [6:0]        second;
            bit                emit;
            r = '0;
            r.all_channels = 1'b1;
            emit = 1'b1;
            if (b[7]) begin
                if (b[7:4] != mbsp_pkg::OP_SYSTEM || b == mbsp_pkg::SYSEX_START) begin
                    running_status = b;
                    have_first = 1'b0;
                    emit = 1'b0;
                end else if (b == mbsp_pkg::SYSEX_END) begin
                    running_status = mbsp_pkg::NO_STATUS;
                    have_first = 1'b0;
                    r.kind = mbsp_pkg::KIND_SYSEX_END;
                    r.opcode = b;
                end else if (is_rt_byte(b)) begin
                    // realtime leaves all state alone
                    r.kind = mbsp_pkg::KIND_REALTIME;
                    r.opcode = b;
                end else begin
                    running_status = mbsp_pkg::NO_STATUS;
                    have_first = 1'b0;
                    r.kind = mbsp_pkg::KIND_SYSCOMMON;
                    r.opcode = b;
                end
            end else if (running_status == mbsp_pkg::SYSEX_START) begin
                r.kind = mbsp_pkg::KIND_SYSEX_DATA;
                r.opcode = mbsp_pkg::SYSEX_START;
                r.data_a = b[6:0];
                r.data_count = 2'd1;
            end else if (!running_status[7] ||
                         running_status[7:4] == mbsp_pkg::OP_SYSTEM) begin
                r.kind = mbsp_pkg::KIND_STRAY;
                r.opcode = mbsp_pkg::NO_STATUS;
                r.data_a = b[6:0];
                r.data_count = 2'd1;
            end else begin
                op = running_status[7:4];
                r.kind = mbsp_pkg::KIND_CHANNEL;
                r.channel = running_status[3:0];
                r.all_channels = 1'b0;
                if (op == mbsp_pkg::OP_PROGRAM || op == mbsp_pkg::OP_PRESSURE) begin
                    have_first = 1'b0;
                    r.opcode = {op, 4'h0};
                    r.data_a = b[6:0];
                    r.data_count = 2'd1;
                end else if (!have_first) begin
                    first_data = b[6:0];
                    have_first = 1'b1;
                    emit = 1'b0;
                end else begin
                    have_first = 1'b0;
                    second = b[6:0];
                    if (op == mbsp_pkg::OP_NOTE_ON && second == 7'd0) begin
                        op = mbsp_pkg::OP_NOTE_OFF;
                        second = mbsp_pkg::NOTE_OFF_VELOCITY;
                    end
                    r.opcode = {op, 4'h0};
                    r.data_a = first_data;
                    r.data_b = second;
                    r.data_count = 2'd2;
                end
            end
            if (emit)
                awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [31:0] tdata, logic [3:0] tuser);
            mbsp_pkg::result_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected item: expected none, got tdata 0x%08h tuser 0x%0h",
                         $time, tdata, tuser);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("kind",         want.kind,         tuser[2:0]);
            compare_field("all_channels", want.all_channels, tuser[3]);
            compare_field("opcode",       want.opcode,       tdata[7:0]);
            compare_field("channel",      want.channel,      tdata[11:8]);
            compare_field("data_a",       want.data_a,       tdata[18:12]);
            compare_field("data_b",       want.data_b,       tdata[25:19]);
            compare_field("data_count",   want.data_count,   tdata[27:26]);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;

    int tx_idle_pct;
    int rx_idle_pct;
    int items_sent;
    int stall_cycles = 0;

    midi_event_checker events_chk;

    midi_byte_stream_parser_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            events_chk.check_result(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // returns at the edge where the byte is taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        events_chk.note_byte(b);
        items_sent++;
    endtask

    task automatic send_status(input logic [3:0] op, input logic [3:0] ch);
        send_byte({op, ch});
    endtask

    function automatic logic [7:0] pick_data();
        logic [7:0] v;
        case ($urandom_range(9))
            0:       v = 8'h00;
            1:       v = 8'h7F;
            default: v = 8'($urandom_range(127));
        endcase
        return v;
    endfunction

    function automatic logic [7:0] pick_rt();
        logic [7:0] v;
        case ($urandom_range(5))
            0:       v = TIMING_CLOCK;
            1:       v = RT_START;
            2:       v = RT_CONTINUE;
            3:       v = RT_STOP;
            4:       v = ACTIVE_SENSE;
            default: v = SYSTEM_RESET;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] pick_syscommon();
        logic [7:0] v;
        case ($urandom_range(7))
            0:       v = MTC_QUARTER;
            1:       v = SONG_POSITION;
            2:       v = SONG_SELECT;
            3:       v = SYS_UNDEF_F4;
            4:       v = SYS_UNDEF_F5;
            5:       v = TUNE_REQUEST;
            6:       v = SYS_UNDEF_F9;
            default: v = SYS_UNDEF_FD;
        endcase
        return v;
    endfunction

    task automatic maybe_realtime();
        if ($urandom_range(9) == 0)
            send_byte(pick_rt());
    endtask

    // status byte, then complete messages under running status
    task automatic channel_burst();
        logic [3:0] op;
        logic [3:0] ch;
        int         need;
        op   = 4'($urandom_range(14, 8));
        ch   = 4'($urandom_range(15));
        need = (op == mbsp_pkg::OP_PROGRAM || op == mbsp_pkg::OP_PRESSURE) ? 1 : 2;
        send_status(op, ch);
        repeat ($urandom_range(6, 1)) begin
            maybe_realtime();
            send_byte(pick_data());
            if (need == 2) begin
                maybe_realtime();
                if (op == mbsp_pkg::OP_NOTE_ON && $urandom_range(3) == 0)
                    send_byte(8'h00);
                else
                    send_byte(pick_data());
            end
        end
        // dangling first byte, dropped by the next status
        if ($urandom_range(4) == 0)
            send_byte(pick_data());
    endtask

    task automatic sysex_block();
        send_byte(mbsp_pkg::SYSEX_START);
        repeat ($urandom_range(8)) begin
            maybe_realtime();
            send_byte(pick_data());
        end
        case ($urandom_range(19))
            0, 1, 2: send_status(4'($urandom_range(14, 8)), 4'($urandom_range(15)));
            3, 4:    send_byte(pick_syscommon());
            default: send_byte(mbsp_pkg::SYSEX_END);
        endcase
    endtask

    task automatic syscommon_block();
        send_byte(pick_syscommon());
        repeat ($urandom_range(2))
            send_byte(pick_data());
    endtask

    task automatic noise_block();
        repeat ($urandom_range(4, 1))
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct);
        int goal;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        goal = items_sent + ITEMS_PER_PHASE;
        while (items_sent < goal) begin
            case ($urandom_range(99)) inside
                [0:49]:  channel_burst();
                [50:69]: sysex_block();
                [70:81]: syscommon_block();
                default: noise_block();
            endcase
        end
    endtask

    initial begin
        events_chk    = new();
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        tx_idle_pct   = 38;
        rx_idle_pct   = 68;
        items_sent    = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_byte(8'h00);                       // data before any status
        send_status(mbsp_pkg::OP_NOTE_ON, 4'h0);
        send_byte(8'h00);
        send_byte(RT_START);                    // realtime inside a message
        send_byte(8'h7F);
        send_byte(8'h7F);                       // running status
        send_byte(8'h00);                       // note-on at zero velocity
        send_status(mbsp_pkg::OP_PROGRAM, 4'hF);
        send_byte(8'h7F);
        send_byte(RT_CONTINUE);
        send_byte(8'h05);
        send_status(mbsp_pkg::OP_PRESSURE, 4'h3);
        send_byte(8'h40);
        send_status(OP_POLY_PRESSURE, 4'h0);
        send_byte(8'h10);                       // cut short by next status
        send_status(OP_CONTROL, 4'h5);
        send_byte(8'h07);
        send_byte(RT_STOP);
        send_byte(8'h64);
        send_status(OP_PITCH_BEND, 4'hA);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(mbsp_pkg::SYSEX_START);
        send_byte(8'h7F);
        send_byte(ACTIVE_SENSE);
        send_byte(8'h00);
        send_byte(mbsp_pkg::SYSEX_END);
        send_byte(SONG_POSITION);
        send_byte(8'h7F);                       // becomes stray data
        send_byte(SYS_UNDEF_F9);
        send_byte(SYS_UNDEF_FD);
        send_byte(TIMING_CLOCK);
        send_byte(SYSTEM_RESET);

        random_phase(38, 68);
        random_phase(68, 38);
        random_phase(0, 0);
        s_axis_tvalid <= 1'b0;

        while (events_chk.awaited.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (events_chk.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
